// ===== rtl/pae_pkg.sv =====
// Shared types, constants and arithmetic helpers for the piecewise
// autocorrelation evaluator. No dependencies; the evaluator top and pae_core import this package.
package pae_pkg;

    localparam int MAX_SAMPLES = 1024;
    localparam int MAX_ROWS    = 4;
    localparam int SAMPLE_BITS = 16;
    localparam int IDX_BITS    = $clog2(MAX_SAMPLES);
    localparam int ROW_BITS    = $clog2(MAX_ROWS);
    localparam int ADDR_BITS   = IDX_BITS + ROW_BITS;
    localparam int STORE_DEPTH = MAX_ROWS * MAX_SAMPLES;
    localparam int POS_BITS    = IDX_BITS + 3;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    localparam logic [1:0] CFG_SAMPLE_COUNT = 2'd0;
    localparam logic [1:0] CFG_ROW_COUNT    = 2'd1;
    localparam logic [1:0] CFG_METHOD       = 2'd2;

    localparam logic [2:0] METHOD_REDUCE_FIRST = 3'd3;
    localparam logic [2:0] METHOD_LAST_VALID   = 3'd5;

    localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
    localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};

    typedef logic signed [POS_BITS-1:0] pos_t;
    typedef logic signed [11:0]         coef_t;
    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    typedef enum logic [1:0] {
        KIND_CONST,
        KIND_LIN,
        KIND_CR
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ROW,
        ST_SR_TEST,
        ST_SR_FETCH,
        ST_SR_CHECK,
        ST_J_START,
        ST_J_TEST,
        ST_FETCH,
        ST_CHECK,
        ST_MAC,
        ST_MULF,
        ST_ACC,
        ST_EV_MUL,
        ST_EV_Q,
        ST_EV_SUM,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic                   operation;
        logic [1:0]             row;
        logic [9:0]             index;
        logic signed [15:0]     sample;
        logic [9:0]             lag_whole;
        logic [15:0]            lag_fraction;
    } cmd_t;

    typedef struct packed {
        logic signed [63:0]     acf_value;
        logic                   invalid_method;
    } res_t;

    typedef struct packed {
        logic [10:0]            sample_count;
        logic [2:0]             row_count;
        logic [2:0]             method;
    } cfg_t;

    localparam int COEF_CONST [4] = '{1680, 0, -1680, 1680};
    localparam int COEF_LIN [16] = '{
        280, 1120, 280, 0,
        -840, 0, 840, 0,
        840, -1680, 840, 0,
        -280, 840, -840, 280};
    localparam int COEF_CR [64] = '{
        3, -60, 213, 1368, 213, -60, 3, 0,
        -7, 168, -1155, 0, 1155, -168, 7, 0,
        -7, -28, 1015, -1960, 1015, -28, -7, 0,
        35, -280, 455, 0, -455, 280, -35, 0,
        -35, 280, -805, 1120, -805, 280, -35, 0,
        7, -42, 91, -70, -35, 98, -63, 14,
        7, -56, 189, -350, 385, -252, 91, -14,
        -3, 21, -63, 105, -105, 63, -21, 3};

    function automatic kind_t kind_of(logic [2:0] method);
        kind_t k;
        unique case (method)
            3'd0, 3'd3: k = KIND_CONST;
            3'd1, 3'd4: k = KIND_LIN;
            default:    k = KIND_CR;
        endcase
        return k;
    endfunction

    // last power index: 1, 3 or 7
    function automatic logic [2:0] last_of(kind_t kind);
        logic [2:0] v;
        unique case (kind)
            KIND_CONST: v = 3'd1;
            KIND_LIN:   v = 3'd3;
            default:    v = 3'd7;
        endcase
        return v;
    endfunction

    function automatic coef_t coef_of(kind_t kind, logic [2:0] i, logic [2:0] m);
        coef_t c;
        unique case (kind)
            KIND_CONST: c = coef_t'(COEF_CONST[{i[0], m[0]}]);
            KIND_LIN:   c = coef_t'(COEF_LIN[{i[1:0], m[1:0]}]);
            default:    c = coef_t'(COEF_CR[{i, m}]);
        endcase
        return c;
    endfunction

    function automatic pos_t offset_of(kind_t kind, logic [2:0] m);
        pos_t p;
        p = pos_t'({{(POS_BITS-3){1'b0}}, m});
        unique case (kind)
            KIND_CONST: p = p;
            KIND_LIN:   p = p - pos_t'(1);
            default:    p = p - pos_t'(3);
        endcase
        return p;
    endfunction

    // lowest lag position worth visiting for this interpolation
    function automatic pos_t first_of(kind_t kind);
        pos_t p;
        unique case (kind)
            KIND_CONST: p = -pos_t'(2);
            KIND_LIN:   p = -pos_t'(1);
            default:    p = pos_t'(1);
        endcase
        return p;
    endfunction

    function automatic logic signed [63:0] sat_add(logic signed [63:0] a,
                                                   logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63])
            return s[64] ? S64_MIN : S64_MAX;
        return s[63:0];
    endfunction

    function automatic logic [63:0] mag_of(logic signed [63:0] v);
        return v[63] ? (~v + 64'd1) : v;
    endfunction

    function automatic logic signed [63:0] from_mag(logic neg, logic [63:0] q);
        if (!neg)
            return q[63] ? S64_MAX : $signed(q);
        if (q[63])
            return S64_MIN;
        return -$signed(q);
    endfunction

endpackage

// ===== rtl/piecewise_autocorrelation_eval.sv =====
// Load: the sample is written when accepted; the next word is accepted the following
// cycle. Query: per row, setup, size reduction trials, then per lag position a fetch
// of the lagged sample and window through the single store read port, plus MAC steps
// if the lagged sample is nonzero (sz = 2, 4, 8); then Horner. Result strobes once; the
// next word is accepted the cycle after it. The receiver cannot stall. Reset: async,
// active low; control regs to reset values, power sums zero, datapath and store undefined.
module piecewise_autocorrelation_eval (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  pae_pkg::cmd_t   command,
    output logic            busy,
    output logic            done,
    output pae_pkg::res_t   result,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [1:0]      cfg_index,
    input  logic [15:0]     cfg_data
);
    import pae_pkg::*;

    cfg_t cfg_reg;
    logic load_we;
    logic go;
    logic rd_en;
    logic [ADDR_BITS-1:0]   rd_addr;
    logic [SAMPLE_BITS-1:0] rd_data;

    assign cfg_ready = 1'b1;
    assign load_we   = start && !busy && command.operation == OP_LOAD;
    assign go        = start && !busy && command.operation == OP_EVAL;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sample_count <= 11'd1024;
            cfg_reg.row_count    <= 3'd1;
            cfg_reg.method       <= 3'd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_SAMPLE_COUNT: cfg_reg.sample_count <= cfg_data[10:0];
                CFG_ROW_COUNT:    cfg_reg.row_count    <= cfg_data[2:0];
                CFG_METHOD:       cfg_reg.method       <= cfg_data[2:0];
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    pae_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (load_we),
        .waddr ({command.row, command.index}),
        .wdata (command.sample),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    pae_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .go           (go),
        .lag_whole    (command.lag_whole),
        .lag_fraction (command.lag_fraction),
        .cfg          (cfg_reg),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .busy         (busy),
        .done         (done),
        .result       (result)
    );

`ifndef NO_ASSERTIONS
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy) else $error("result strobe outside a query");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy) else $error("still busy after result");
    a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
        go |=> busy) else $error("query not started");
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.invalid_method |-> result.acf_value == 64'sd0)
        else $error("invalid method with nonzero value");
`endif

endmodule

// ===== rtl/pae_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module pae_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/pae_core.sv =====
// Query sequencer and datapath: size reduction, per-power multiply-accumulate over
// the sample store, and Horner evaluation. Depends on pae_pkg.
module pae_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            go,
    input  logic [9:0]                      lag_whole,
    input  logic [15:0]                     lag_fraction,
    input  pae_pkg::cfg_t                   cfg,
    output logic                            rd_en,
    output logic [pae_pkg::ADDR_BITS-1:0]   rd_addr,
    input  logic [pae_pkg::SAMPLE_BITS-1:0] rd_data,
    output logic                            busy,
    output logic                            done,
    output pae_pkg::res_t                   result
);
    import pae_pkg::*;

    state_t state_reg, state_next;
    logic [2:0]  r_reg, r_next;
    logic [9:0]  dn_reg, dn_next;
    logic [10:0] nn_reg, nn_next;
    pos_t        j_reg, j_next;
    logic [3:0]  fc_reg, fc_next;
    logic [2:0]  i_reg, i_next;
    logic [2:0]  m_reg, m_next;
    logic [2:0]  ei_reg, ei_next;
    logic        zero_reg, zero_next;
    logic        invalid_reg, invalid_next;
    logic        neg_reg, neg_next;
    logic [9:0]  iy_reg, iy_next;
    logic [15:0] frac_reg, frac_next;
    logic signed [31:0] d_reg, d_next;
    logic signed [47:0] p_reg, p_next;
    sample_t     f0_reg, f0_next;
    sample_t     w_reg [8];
    sample_t     w_next [8];
    sample_t     sr_reg [4];
    sample_t     sr_next [4];
    logic signed [63:0] ps_reg [8];
    logic signed [63:0] ps_next [8];
    logic signed [63:0] res_reg, res_next;
    logic [47:0] ph_reg, ph_next;
    logic [47:0] pl_reg, pl_next;
    logic [63:0] q_reg, q_next;

    kind_t       kind;
    logic [2:0]  last;
    logic        reduce;
    logic [10:0] n_use;
    logic [2:0]  rows;
    pos_t        k_pos;
    pos_t        k_lim;
    logic        k_out;
    sample_t     rd_val;
    logic [2:0]  ps_sel;
    logic signed [63:0] ps_rd;
    pos_t        j_first;
    pos_t        j_end;
    logic [11:0] dn_span;
    logic signed [16:0] d1, d0, de;
    logic [16:0] a1, a0, ae, amax;
    logic        sr_pass;
    logic [47:0] pl_round;
    logic [63:0] res_mag;

    assign kind   = kind_of(cfg.method);
    assign last   = last_of(kind);
    assign reduce = cfg.method >= METHOD_REDUCE_FIRST;
    assign n_use  = (cfg.sample_count > 11'(MAX_SAMPLES)) ? 11'(MAX_SAMPLES)
                                                          : cfg.sample_count;
    assign rows   = (cfg.row_count > 3'(MAX_ROWS)) ? 3'(MAX_ROWS) : cfg.row_count;
    assign rd_val = zero_reg ? '0 : $signed(rd_data);
    assign ps_rd  = ps_reg[ps_sel];

    // sample position for the current fetch and its range check
    always_comb
    begin
        k_pos = '0;
        k_lim = pos_t'({2'b00, nn_reg});
        if (state_reg == ST_SR_FETCH)
        begin
            k_lim = pos_t'({2'b00, n_use});
            unique case (fc_reg)
                4'd0:    k_pos = '0;
                4'd1:    k_pos = pos_t'(1);
                4'd2:    k_pos = pos_t'({2'b00, n_use}) - pos_t'({3'b000, dn_reg})
                                 - pos_t'(1);
                4'd3:    k_pos = pos_t'({2'b00, n_use}) - pos_t'({3'b000, dn_reg})
                                 - pos_t'(2);
                default: k_pos = '0;
            endcase
        end
        else if (fc_reg == 4'd0)
            k_pos = j_reg - pos_t'({3'b000, iy_reg});
        else
            k_pos = j_reg + offset_of(kind, 3'(fc_reg - 4'd1));
        k_out = (k_pos < 0) || (k_pos >= k_lim);
    end

    assign dn_span  = {2'b00, dn_reg} + {2'b00, dn_reg} + {2'b00, dn_reg} + 12'd3;
    assign j_first  = (pos_t'({3'b000, iy_reg}) > first_of(kind))
                      ? pos_t'({3'b000, iy_reg}) : first_of(kind);
    assign j_end    = pos_t'({2'b00, nn_reg}) + offset_of(kind, last);
    assign d1       = {sr_reg[1][15], sr_reg[1]} - {sr_reg[0][15], sr_reg[0]};
    assign d0       = {sr_reg[0][15], sr_reg[0]} - {sr_reg[2][15], sr_reg[2]};
    assign de       = {sr_reg[2][15], sr_reg[2]} - {sr_reg[3][15], sr_reg[3]};
    assign a1       = d1[16] ? 17'(-d1) : 17'(d1);
    assign a0       = d0[16] ? 17'(-d0) : 17'(d0);
    assign ae       = de[16] ? 17'(-de) : 17'(de);
    assign amax     = (a1 > ae) ? a1 : ae;
    assign sr_pass  = (a0 < amax) && !((de > 0 && d1 < 0) || (de < 0 && d1 > 0));
    assign pl_round = pl_reg + 48'd32768;
    assign res_mag  = mag_of(res_reg);

    always_comb
    begin
        unique case (state_reg)
            ST_ROW:    ps_sel = last;
            ST_EV_SUM: ps_sel = ei_reg - 3'd1;
            default:   ps_sel = i_reg;
        endcase
    end

    // next state and datapath
    always_comb
    begin
        state_next   = state_reg;
        r_next       = r_reg;
        dn_next      = dn_reg;
        nn_next      = nn_reg;
        j_next       = j_reg;
        fc_next      = fc_reg;
        i_next       = i_reg;
        m_next       = m_reg;
        ei_next      = ei_reg;
        zero_next    = k_out;
        invalid_next = invalid_reg;
        neg_next     = neg_reg;
        iy_next      = iy_reg;
        frac_next    = frac_reg;
        d_next       = d_reg;
        p_next       = p_reg;
        f0_next      = f0_reg;
        w_next       = w_reg;
        sr_next      = sr_reg;
        ps_next      = ps_reg;
        res_next     = res_reg;
        ph_next      = ph_reg;
        pl_next      = pl_reg;
        q_next       = q_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (go)
                begin
                    iy_next   = lag_whole;
                    frac_next = lag_fraction;
                    r_next    = '0;
                    res_next  = '0;
                    for (int e = 0; e < 8; e++)
                        ps_next[e] = '0;
                    invalid_next = cfg.method > METHOD_LAST_VALID;
                    state_next   = (cfg.method > METHOD_LAST_VALID) ? ST_DONE : ST_ROW;
                end
            end
            ST_ROW:
            begin
                if (r_reg == rows)
                begin
                    res_next   = ps_rd;
                    ei_next    = last;
                    state_next = ST_EV_MUL;
                end
                else if (reduce)
                begin
                    dn_next    = '0;
                    state_next = ST_SR_TEST;
                end
                else
                begin
                    nn_next    = n_use;
                    state_next = ST_J_START;
                end
            end
            ST_SR_TEST:
            begin
                fc_next = '0;
                if (dn_span <= {1'b0, n_use})
                    state_next = ST_SR_FETCH;
                else
                begin
                    nn_next    = n_use;
                    state_next = ST_J_START;
                end
            end
            ST_SR_FETCH:
            begin
                if (fc_reg != 4'd0)
                    sr_next[2'(fc_reg - 4'd1)] = rd_val;
                fc_next = fc_reg + 4'd1;
                if (fc_reg == 4'd4)
                    state_next = ST_SR_CHECK;
            end
            ST_SR_CHECK:
            begin
                if (sr_pass)
                begin
                    nn_next    = n_use - {1'b0, dn_reg};
                    state_next = ST_J_START;
                end
                else
                begin
                    dn_next    = dn_reg + 10'd1;
                    state_next = ST_SR_TEST;
                end
            end
            ST_J_START:
            begin
                j_next     = j_first;
                state_next = ST_J_TEST;
            end
            ST_J_TEST:
            begin
                fc_next = '0;
                if (j_reg < j_end)
                    state_next = ST_FETCH;
                else
                begin
                    r_next     = r_reg + 3'd1;
                    state_next = ST_ROW;
                end
            end
            ST_FETCH:
            begin
                // item 0 is the lagged sample, items 1.. fill the window
                if (fc_reg == 4'd1)
                    f0_next = rd_val;
                else if (fc_reg != 4'd0)
                    w_next[3'(fc_reg - 4'd2)] = rd_val;
                fc_next = fc_reg + 4'd1;
                if (fc_reg == {1'b0, last} + 4'd2)
                    state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                i_next = '0;
                m_next = '0;
                d_next = '0;
                if (f0_reg == 0)
                begin
                    j_next     = j_reg + pos_t'(1);
                    state_next = ST_J_TEST;
                end
                else
                    state_next = ST_MAC;
            end
            ST_MAC:
            begin
                d_next = d_reg + 32'(coef_of(kind, i_reg, m_reg)) * 32'(w_reg[m_reg]);
                m_next = m_reg + 3'd1;
                if (m_reg == last)
                    state_next = ST_MULF;
            end
            ST_MULF:
            begin
                p_next     = f0_reg * d_reg;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                ps_next[i_reg] = sat_add(ps_rd, 64'(p_reg));
                m_next = '0;
                d_next = '0;
                i_next = i_reg + 3'd1;
                if (i_reg == last)
                begin
                    j_next     = j_reg + pos_t'(1);
                    state_next = ST_J_TEST;
                end
                else
                    state_next = ST_MAC;
            end
            ST_EV_MUL:
            begin
                neg_next   = res_reg[63];
                ph_next    = res_mag[63:32] * frac_reg;
                pl_next    = res_mag[31:0] * frac_reg;
                state_next = ST_EV_Q;
            end
            ST_EV_Q:
            begin
                q_next     = {ph_reg, 16'd0} + {32'd0, pl_round[47:16]};
                state_next = ST_EV_SUM;
            end
            ST_EV_SUM:
            begin
                res_next   = sat_add(ps_rd, from_mag(neg_reg, q_reg));
                ei_next    = ei_reg - 3'd1;
                state_next = (ei_reg == 3'd1) ? ST_DONE : ST_EV_MUL;
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        rd_en   = (state_reg == ST_SR_FETCH && fc_reg < 4'd4)
                  || (state_reg == ST_FETCH && fc_reg <= {1'b0, last} + 4'd1);
        rd_addr = {r_reg[ROW_BITS-1:0], k_pos[IDX_BITS-1:0]};
        busy    = state_reg != ST_IDLE;
        done    = state_reg == ST_DONE;
        result.acf_value      = res_reg;
        result.invalid_method = invalid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            r_reg       <= '0;
            dn_reg      <= '0;
            fc_reg      <= '0;
            i_reg       <= '0;
            m_reg       <= '0;
            ei_reg      <= '0;
            invalid_reg <= 1'b0;
            for (int e = 0; e < 8; e++)
                ps_reg[e] <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            r_reg       <= r_next;
            dn_reg      <= dn_next;
            fc_reg      <= fc_next;
            i_reg       <= i_next;
            m_reg       <= m_next;
            ei_reg      <= ei_next;
            invalid_reg <= invalid_next;
            ps_reg      <= ps_next;
        end
    end

    always_ff @(posedge clk)
    begin
        nn_reg   <= nn_next;
        j_reg    <= j_next;
        zero_reg <= zero_next;
        neg_reg  <= neg_next;
        iy_reg   <= iy_next;
        frac_reg <= frac_next;
        d_reg    <= d_next;
        p_reg    <= p_next;
        f0_reg   <= f0_next;
        w_reg    <= w_next;
        sr_reg   <= sr_next;
        res_reg  <= res_next;
        ph_reg   <= ph_next;
        pl_reg   <= pl_next;
        q_reg    <= q_next;
    end

endmodule
